@@ rtl/float_to_decimal_text_macros.svh @@
// Assertion macros for the float-to-decimal text formatter.
// Used by rtl/fdt_ctrl.sv; expects signals clk and rst in scope.
`ifndef FLOAT_TO_DECIMAL_TEXT_MACROS_SVH
`define FLOAT_TO_DECIMAL_TEXT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FDT_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdt same-cycle check failed");
`define FDT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdt next-cycle check failed");
`else
`define FDT_ASSERT_IMPL(name, ante, cons)
`define FDT_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ rtl/fdt_pkg.sv @@
// Shared types and constants of the float-to-decimal text formatter.
// No dependencies; imported by fdt_ctrl, fdt_dp and float_to_decimal_text.
package fdt_pkg;

  localparam int MAX_PRECISION = 6;
  localparam int MULT_W        = 20;   // holds 10^MAX_PRECISION
  localparam int W_W           = 46;   // rounding work register
  localparam int INT_DIGITS    = 10;

  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_DOT   = 7'h2E;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_SIGN,
    SEL_INT,
    SEL_DOT,
    SEL_FRAC
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      mul;
    logic      norm_step;
    logic      add_half;
    logic      take_frac;
    logic      carry;
    logic      int_start;
    logic      int_step;
    logic      frac_start;
    logic      frac_step;
    logic      load_out;
    emit_sel_t sel;
    logic      last;
  } cmd_t;

  typedef struct packed {
    logic       fzero;
    logic       norm_done;
    logic       q_zero;
    logic       frac_done;
    logic       neg;
    logic [3:0] nint;
    logic [4:0] len;
    logic [4:0] emit_max;
  } sts_t;

  function automatic logic [MULT_W-1:0] pow10(input logic [2:0] p);
    logic [MULT_W-1:0] m;
    unique case (p)
      3'd0:    m = 20'd1;
      3'd1:    m = 20'd10;
      3'd2:    m = 20'd100;
      3'd3:    m = 20'd1000;
      3'd4:    m = 20'd10000;
      3'd5:    m = 20'd100000;
      default: m = 20'd1000000;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/fdt_dp.sv @@
// Datapath of the formatter: decode, fraction rounding, digit stacks, output register.
// Depends on fdt_pkg; driven by commands from fdt_ctrl.
module fdt_dp import fdt_pkg::*; (
  input  logic        clk,
  input  logic [31:0] value_bits,
  input  logic [3:0]  digits,
  input  logic [4:0]  room,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [6:0]  out_char,
  output logic        char_valid,
  output logic        last,
  output logic [4:0]  full_length
);

  logic              neg, fzero;
  logic [2:0]        prec;
  logic [4:0]        emit_max;
  logic [5:0]        sh;
  logic [31:0]       ipart;
  logic [23:0]       frac;
  logic [MULT_W-1:0] fpart;
  logic [W_W-1:0]    w;
  logic [5:0]        k;
  logic              sticky;
  logic [31:0]       x;
  logic [3:0]        nint;
  logic [2:0]        fcnt;
  logic [3:0]        idig [INT_DIGITS];
  logic [3:0]        fdig [MAX_PRECISION];

  // decode
  logic [7:0]        ex;
  logic [22:0]       mt;
  logic [23:0]       mant;
  logic signed [9:0] eexp;
  logic [9:0]        shf;
  logic              d_sat, d_nan, d_nonneg;
  logic [31:0]       d_ipart;
  logic [23:0]       d_frac;

  always_comb begin
    ex       = value_bits[30:23];
    mt       = value_bits[22:0];
    mant     = (ex == 8'd0) ? {1'b0, mt} : {1'b1, mt};
    eexp     = (ex == 8'd0) ? -10'sd149 : ($signed({2'b00, ex}) - 10'sd150);
    shf      = 10'(-eexp);
    d_sat    = (ex >= 8'd158);
    d_nan    = (ex == 8'hFF) && (mt != 23'd0);
    d_nonneg = !eexp[9];
    if (d_sat) begin
      d_ipart = 32'h7FFF_FFFF;
      d_frac  = 24'd0;
    end else if (d_nonneg) begin
      d_ipart = {8'd0, mant} << eexp[2:0];
      d_frac  = 24'd0;
    end else if (shf >= 10'd24) begin
      d_ipart = 32'd0;
      d_frac  = mant;
    end else begin
      d_ipart = {8'd0, mant} >> shf[4:0];
      d_frac  = mant & ~(24'hFF_FFFF << shf[4:0]);
    end
  end

  // rounding to 24 significant bits, nearest even
  logic [MULT_W-1:0] mult;
  logic              up;
  logic [24:0]       mr;
  logic [W_W:0]      rsh;
  logic [W_W-1:0]    rnd;
  logic [W_W-1:0]    fsh;

  always_comb begin
    mult = pow10(prec);
    up   = w[0] && (sticky || w[1]);
    mr   = {1'b0, w[24:1]} + 25'(up);
    rsh  = {22'd0, mr} << (k + 6'd1);
    rnd  = w[24] ? rsh[W_W-1:0] : w;
    fsh  = rnd >> sh;
  end

  // divide by ten through reciprocal multiply
  logic [63:0] prod;
  logic [31:0] q;
  logic [31:0] rem;
  always_comb begin
    prod = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
    q    = {3'd0, prod[63:35]};
    rem  = x - ((q << 3) + (q << 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg      <= value_bits[31] && (value_bits[30:0] != 31'd0) && !d_nan;
      fzero    <= d_sat || d_nonneg || (shf >= 10'd45);
      prec     <= (digits > 4'(MAX_PRECISION)) ? 3'(MAX_PRECISION) : digits[2:0];
      emit_max <= (room == 5'd0) ? 5'd0 : room - 5'd1;
      sh       <= shf[5:0];
      ipart    <= d_ipart;
      frac     <= d_frac;
      fpart    <= '0;
    end
    if (cmd.mul) begin
      w      <= {2'b00, 44'(frac * mult)};
      k      <= '0;
      sticky <= 1'b0;
    end
    if (cmd.norm_step) begin
      w      <= w >> 1;
      sticky <= sticky | w[0];
      k      <= k + 6'd1;
    end
    if (cmd.add_half) begin
      w      <= rnd + (46'd1 << (sh - 6'd1));
      k      <= '0;
      sticky <= 1'b0;
    end
    if (cmd.take_frac) fpart <= fsh[MULT_W-1:0];
    if (cmd.carry && (fpart >= mult)) begin
      ipart <= ipart + 32'd1;
      fpart <= fpart - mult;
    end
    if (cmd.int_start) begin
      x    <= ipart;
      nint <= '0;
    end
    if (cmd.frac_start) begin
      x    <= {12'd0, fpart};
      fcnt <= '0;
    end
    if (cmd.int_step || cmd.frac_step) x <= q;
    if (cmd.int_step) begin
      nint <= nint + 4'd1;
      idig[0] <= rem[3:0];
      for (int i = 1; i < INT_DIGITS; i++) idig[i] <= idig[i-1];
    end else if (cmd.load_out && cmd.sel == SEL_INT) begin
      for (int i = 0; i < INT_DIGITS - 1; i++) idig[i] <= idig[i+1];
    end
    if (cmd.frac_step) begin
      fcnt <= fcnt + 3'd1;
      fdig[0] <= rem[3:0];
      for (int i = 1; i < MAX_PRECISION; i++) fdig[i] <= fdig[i-1];
    end else if (cmd.load_out && cmd.sel == SEL_FRAC) begin
      for (int i = 0; i < MAX_PRECISION - 1; i++) fdig[i] <= fdig[i+1];
    end
    if (cmd.load_out) begin
      last        <= cmd.last;
      full_length <= sts.len;
      char_valid  <= (cmd.sel != SEL_NONE);
      unique case (cmd.sel)
        SEL_SIGN: out_char <= CHAR_MINUS;
        SEL_INT:  out_char <= {3'b011, idig[0]};
        SEL_DOT:  out_char <= CHAR_DOT;
        SEL_FRAC: out_char <= {3'b011, fdig[0]};
        default:  out_char <= 7'd0;
      endcase
    end
  end

  always_comb begin
    sts.fzero     = fzero;
    sts.norm_done = (w[W_W-1:25] == '0);
    sts.q_zero    = (q == 32'd0);
    sts.frac_done = (fcnt == prec);
    sts.neg       = neg;
    sts.nint      = nint;
    sts.len       = 5'(neg) + 5'(nint) + ((prec != 3'd0) ? 5'(prec) + 5'd1 : 5'd0);
    sts.emit_max  = emit_max;
  end

endmodule

@@ rtl/fdt_ctrl.sv @@
// Controller state machine of the formatter: sequences rounding, digits and emission.
// Depends on fdt_pkg and float_to_decimal_text_macros.svh; drives fdt_dp.
`include "float_to_decimal_text_macros.svh"
module fdt_ctrl import fdt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_valid,
  output logic s_ready,
  output logic m_valid,
  input  logic m_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CHECK  = 10'b00_0000_0010,
    S_NORM1  = 10'b00_0000_0100,
    S_NORM2  = 10'b00_0000_1000,
    S_CARRY  = 10'b00_0001_0000,
    S_ISTART = 10'b00_0010_0000,
    S_IDIG   = 10'b00_0100_0000,
    S_FSTART = 10'b00_1000_0000,
    S_FDIG   = 10'b01_0000_0000,
    S_EMIT   = 10'b10_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [4:0] pos, pos_next;
  logic       ovalid, ovalid_next;
  logic [4:0] emit_n;
  logic [4:0] j;
  logic       is_last;
  emit_sel_t  sel;

  assign s_ready = (state == S_IDLE);
  assign m_valid = ovalid;

  always_comb begin
    emit_n  = (sts.emit_max < sts.len) ? sts.emit_max : sts.len;
    j       = pos - 5'(sts.neg);
    is_last = (emit_n == 5'd0) || (pos + 5'd1 == emit_n);
    if (emit_n == 5'd0)               sel = SEL_NONE;
    else if (sts.neg && pos == 5'd0)  sel = SEL_SIGN;
    else if (j < 5'(sts.nint))        sel = SEL_INT;
    else if (j == 5'(sts.nint))       sel = SEL_DOT;
    else                              sel = SEL_FRAC;
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    cmd        = '0;
    cmd.sel    = sel;
    cmd.last   = is_last;
    unique case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.fzero) begin
          state_next = S_ISTART;
        end else begin
          cmd.mul    = 1'b1;
          state_next = S_NORM1;
        end
      end
      S_NORM1: begin
        if (sts.norm_done) begin
          cmd.add_half = 1'b1;
          state_next   = S_NORM2;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_NORM2: begin
        if (sts.norm_done) begin
          cmd.take_frac = 1'b1;
          state_next    = S_CARRY;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_CARRY: begin
        cmd.carry  = 1'b1;
        state_next = S_ISTART;
      end
      S_ISTART: begin
        cmd.int_start = 1'b1;
        state_next    = S_IDIG;
      end
      S_IDIG: begin
        cmd.int_step = 1'b1;
        if (sts.q_zero) state_next = S_FSTART;
      end
      S_FSTART: begin
        cmd.frac_start = 1'b1;
        pos_next       = 5'd0;
        state_next     = S_FDIG;
      end
      S_FDIG: begin
        if (sts.frac_done) state_next = S_EMIT;
        else               cmd.frac_step = 1'b1;
      end
      S_EMIT: begin
        if (!ovalid || m_ready) begin
          cmd.load_out = 1'b1;
          pos_next     = pos + 5'd1;
          if (is_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_next = ovalid;
    if (cmd.load_out)  ovalid_next = 1'b1;
    else if (m_ready)  ovalid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      pos    <= '0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
      pos    <= pos_next;
    end
  end

  `FDT_ASSERT_NEXT(a_last_returns_idle, cmd.load_out && cmd.last, state == S_IDLE)
  `FDT_ASSERT_IMPL(a_pos_in_range, state == S_EMIT && emit_n != 5'd0, pos < emit_n)
  `FDT_ASSERT_IMPL(a_int_digits, state == S_EMIT, sts.nint != 4'd0 && sts.nint <= 4'd10)

endmodule

@@ rtl/float_to_decimal_text.sv @@
// Top level of the float-to-decimal text formatter.
// Depends on fdt_pkg, fdt_ctrl and fdt_dp.
//
//  channel  | direction | fields (tdata from bit 0 up)              | side bits
//  s_axis   | in        | value_bits[31:0] digits[35:32] room[40:36] | -
//  m_axis   | out       | out_char[6:0] full_length[11:7]            | tuser=char_valid, tlast=last
//
// A value with no fraction bits, an out-of-range or a tiny value skips
// rounding; otherwise two normalization loops of the shared rounding unit
// run (one bit a cycle). Then the divide-by-ten unit produces the decimal
// digits, and the characters are emitted one at a time.
// Reset clears the controller state, character position and output valid flag only.
// A new item is taken while the last character still waits in the output
// register; a stall on m_axis holds emission of further characters.
module float_to_decimal_text import fdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value_bits, digits, room, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_char, full_length, zero pad
  output logic        m_axis_tuser,   // char_valid
  output logic        m_axis_tlast    // last
);

  cmd_t       cmd;
  sts_t       sts;
  logic [6:0] out_char;
  logic [4:0] full_length;

  // sequence the work of one item
  fdt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // decode, round, convert and hold the outgoing character
  fdt_dp u_dp (
    .clk         (clk),
    .value_bits  (s_axis_tdata[31:0]),
    .digits      (s_axis_tdata[35:32]),
    .room        (s_axis_tdata[40:36]),
    .cmd         (cmd),
    .sts         (sts),
    .out_char    (out_char),
    .char_valid  (m_axis_tuser),
    .last        (m_axis_tlast),
    .full_length (full_length)
  );

  assign m_axis_tdata = {4'd0, full_length, out_char};

endmodule
